// ===== rtl/cgt_pkg.sv =====
// Shared types and constants of the CAM generation trigger.
// Holds register indexes, reset values, field widths and the packed item layouts.
// No dependencies.
`default_nettype none

package cgt_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_MIN_INTERVAL  = 3'd0;
    localparam logic [2:0] REG_MAX_INTERVAL  = 3'd1;
    localparam logic [2:0] REG_HEADING_THR   = 3'd2;
    localparam logic [2:0] REG_POSITION_THR  = 3'd3;
    localparam logic [2:0] REG_SPEED_THR     = 3'd4;
    localparam logic [2:0] REG_DCC_ENABLE    = 3'd5;
    localparam logic [2:0] REG_RATE_MODE     = 3'd6;
    localparam logic [2:0] REG_STARTUP_TIME  = 3'd7;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Reset values of the configuration registers
    localparam logic [15:0] RST_MIN_INTERVAL = 16'd100;
    localparam logic [15:0] RST_MAX_INTERVAL = 16'd1000;
    localparam logic [10:0] RST_HEADING_THR  = 11'd40;
    localparam logic [19:0] RST_POSITION_THR = 20'd400;
    localparam logic [15:0] RST_SPEED_THR    = 16'd50;

    // Rate mode bits
    localparam int RATE_FIXED_BIT = 0;
    localparam int RATE_EXPO_BIT  = 1;

    // Fixed behavior constants
    localparam logic [31:0] LOW_FREQ_INTERVAL_MS = 32'd100;
    localparam logic [12:0] FULL_CIRCLE_DD       = 13'd3600;
    localparam logic [1:0]  LOW_DYNAMICS_LIMIT   = 2'd3;
    localparam logic [1:0]  LOW_DYNAMICS_SAT     = 2'd3;

    // Packed stream widths
    localparam int S_TDATA_W = 160;
    localparam int M_TDATA_W = 24;

    typedef struct packed {
        logic [15:0] random_extra_ms;
        logic [15:0] dcc_interval_ms;
        logic [15:0] speed_now;
        logic [31:0] pos_y_cm;
        logic [31:0] pos_x_cm;
        logic [11:0] heading_now;
        logic [31:0] now_ms;
    } tick_t;

    typedef struct packed {
        logic [15:0] message_count;
        logic        low_freq_container;
        logic        send;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/cam_generation_trigger.sv =====
// CAM generation trigger: top level with input register, decision logic and result register.
// Depends on cgt_pkg for register indexes, reset values and item layouts.
// Contains no submodules.
//
// Usage:
//   s_* carries one check tick per request (time, heading, position, speed, congestion
//   interval, random sample). m_* returns exactly one result per tick: send flag,
//   low-frequency-container flag and the count of messages sent before this one.
//   cfg_* writes one configuration register per request; it is always ready and must
//   only be used while no tick is in flight.
// Decision: a tick accepted into the input register is decided combinationally in the following cycle
//   and its result is loaded into the result register when that register is free or being drained.
// Throughput: one tick per clock while m_tready keeps the result register draining. The input
//   register and the result register hold one request each; the input side keeps taking ticks
//   while the result register drains. The decision for a tick reads the history state updated by
//   the previous tick, so the rate is set by the combinational compare/update path in the
//   decision stage (three 20x20 multipliers for the position distance test).
// Stall: when m_tready is low the result is held; the input register fills and then
//   s_tready drops until the result is taken.
// Reset: aresetn low clears both stages, loads register reset values and restores
//   the history (first message will carry the low-frequency container).
`default_nettype none

module cam_generation_trigger (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // now_ms[31:0], heading_now[43:32], pos_x_cm[75:44], pos_y_cm[107:76],
    // speed_now[123:108], dcc_interval_ms[139:124], random_extra_ms[155:140], zero pad
    input  wire logic [cgt_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    // send[0], low_freq_container[1], message_count[17:2], zero pad
    output      logic [cgt_pkg::M_TDATA_W-1:0]   m_tdata,
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic                            cfg_valid,
    output      logic                            cfg_ready,
    input  wire logic [cgt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [cgt_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import cgt_pkg::*;

    // ---------------- configuration registers ----------------
    logic [15:0] min_iv_reg;
    logic [15:0] max_iv_reg;
    logic [10:0] hdg_thr_reg;
    logic [19:0] pos_thr_reg;
    logic [15:0] spd_thr_reg;
    logic        dcc_en_reg;
    logic [1:0]  rate_mode_reg;
    logic [31:0] startup_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_iv_reg    <= RST_MIN_INTERVAL;
            max_iv_reg    <= RST_MAX_INTERVAL;
            hdg_thr_reg   <= RST_HEADING_THR;
            pos_thr_reg   <= RST_POSITION_THR;
            spd_thr_reg   <= RST_SPEED_THR;
            dcc_en_reg    <= 1'b0;
            rate_mode_reg <= 2'd0;
            startup_reg   <= 32'd0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_MIN_INTERVAL: min_iv_reg    <= cfg_data[15:0];
                REG_MAX_INTERVAL: max_iv_reg    <= cfg_data[15:0];
                REG_HEADING_THR:  hdg_thr_reg   <= cfg_data[10:0];
                REG_POSITION_THR: pos_thr_reg   <= cfg_data[19:0];
                REG_SPEED_THR:    spd_thr_reg   <= cfg_data[15:0];
                REG_DCC_ENABLE:   dcc_en_reg    <= cfg_data[0];
                REG_RATE_MODE:    rate_mode_reg <= cfg_data[1:0];
                REG_STARTUP_TIME: startup_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- input register ----------------
    tick_t   tick_reg;
    logic    tick_valid_reg;
    result_t res_reg;
    logic    res_valid_reg;
    logic    advance;

    // Decide the held tick whenever the result register is free or being drained.
    assign advance  = !res_valid_reg || m_tready;
    assign s_tready = !tick_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_valid_reg <= 1'b0;
        end else if (s_tready) begin
            tick_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            tick_reg <= tick_t'(s_tdata[$bits(tick_t)-1:0]);
        end
    end

    // ---------------- history state ----------------
    logic [31:0] last_send_reg,  last_send_next;
    logic [31:0] last_low_reg,   last_low_next;
    logic        first_low_reg,  first_low_next;
    logic [11:0] last_hdg_reg,   last_hdg_next;
    logic [31:0] last_x_reg,     last_x_next;
    logic [31:0] last_y_reg,     last_y_next;
    logic [15:0] last_spd_reg,   last_spd_next;
    logic [15:0] adapt_iv_reg,   adapt_iv_next;
    logic [1:0]  low_dyn_reg,    low_dyn_next;
    logic [16:0] nonper_iv_reg,  nonper_iv_next;
    logic [15:0] sent_cnt_reg,   sent_cnt_next;
    result_t     res_next;

    // ---------------- decision logic ----------------
    logic        fixed_mode;
    logic        expo_mode;
    logic [16:0] final_iv;
    logic [15:0] dcc_lo_clamped;
    logic [31:0] elapsed;
    logic        due;
    logic [12:0] hdg_diff;
    logic [11:0] hdg_abs;
    logic [11:0] hdg_mod;
    logic [12:0] hdg_upper;
    logic        hdg_changed;
    logic [32:0] dx_diff;
    logic [32:0] dy_diff;
    logic [31:0] dx_abs;
    logic [31:0] dy_abs;
    logic        dx_big;
    logic        dy_big;
    logic [39:0] dx_sq;
    logic [39:0] dy_sq;
    logic [39:0] thr_sq;
    logic [40:0] dist_sq;
    logic        pos_changed;
    logic [16:0] spd_diff;
    logic [15:0] spd_abs;
    logic        spd_changed;
    logic [1:0]  low_dyn_inc;
    logic        send;
    logic        low_fc;

    assign fixed_mode = rate_mode_reg[RATE_FIXED_BIT];
    assign expo_mode  = rate_mode_reg[RATE_EXPO_BIT];
    assign elapsed    = tick_reg.now_ms - last_send_reg;

    // Clamp the congestion interval: raise to min first, then cut at max.
    assign dcc_lo_clamped = (tick_reg.dcc_interval_ms > min_iv_reg) ?
                            tick_reg.dcc_interval_ms : min_iv_reg;

    always_comb begin
        priority if (dcc_en_reg) begin
            final_iv = {1'b0, (dcc_lo_clamped < max_iv_reg) ? dcc_lo_clamped : max_iv_reg};
        end else if (expo_mode) begin
            final_iv = nonper_iv_reg;
        end else begin
            final_iv = {1'b0, min_iv_reg};
        end
    end

    assign due = (elapsed >= {15'd0, final_iv}) && (tick_reg.now_ms > startup_reg);

    // Heading: absolute difference folded once around the full circle.
    assign hdg_diff  = {1'b0, tick_reg.heading_now} - {1'b0, last_hdg_reg};
    assign hdg_abs   = hdg_diff[12] ? 12'(-hdg_diff) : hdg_diff[11:0];
    assign hdg_mod   = ({1'b0, hdg_abs} >= FULL_CIRCLE_DD) ?
                       12'({1'b0, hdg_abs} - FULL_CIRCLE_DD) : hdg_abs;
    assign hdg_upper = FULL_CIRCLE_DD - {2'b00, hdg_thr_reg};
    assign hdg_changed = ({1'b0, hdg_mod} > {2'b00, hdg_thr_reg}) &&
                         ({1'b0, hdg_mod} < hdg_upper);

    // Position: any axis beyond the threshold decides at once, else square the narrow parts.
    assign dx_diff = {tick_reg.pos_x_cm[31], tick_reg.pos_x_cm} - {last_x_reg[31], last_x_reg};
    assign dy_diff = {tick_reg.pos_y_cm[31], tick_reg.pos_y_cm} - {last_y_reg[31], last_y_reg};
    assign dx_abs  = dx_diff[32] ? 32'(-dx_diff) : dx_diff[31:0];
    assign dy_abs  = dy_diff[32] ? 32'(-dy_diff) : dy_diff[31:0];
    assign dx_big  = dx_abs > {12'd0, pos_thr_reg};
    assign dy_big  = dy_abs > {12'd0, pos_thr_reg};
    assign dx_sq   = {20'd0, dx_abs[19:0]} * {20'd0, dx_abs[19:0]};
    assign dy_sq   = {20'd0, dy_abs[19:0]} * {20'd0, dy_abs[19:0]};
    assign thr_sq  = {20'd0, pos_thr_reg} * {20'd0, pos_thr_reg};
    assign dist_sq = {1'b0, dx_sq} + {1'b0, dy_sq};
    assign pos_changed = dx_big || dy_big || (dist_sq > {1'b0, thr_sq});

    // Speed: signed difference, magnitude against threshold.
    assign spd_diff = {tick_reg.speed_now[15], tick_reg.speed_now} -
                      {last_spd_reg[15], last_spd_reg};
    assign spd_abs  = spd_diff[16] ? 16'(-spd_diff) : spd_diff[15:0];
    assign spd_changed = spd_abs > spd_thr_reg;

    assign low_dyn_inc = (low_dyn_reg < LOW_DYNAMICS_SAT) ? low_dyn_reg + 2'd1 : low_dyn_reg;

    always_comb begin
        last_send_next = last_send_reg;
        last_low_next  = last_low_reg;
        first_low_next = first_low_reg;
        last_hdg_next  = last_hdg_reg;
        last_x_next    = last_x_reg;
        last_y_next    = last_y_reg;
        last_spd_next  = last_spd_reg;
        adapt_iv_next  = adapt_iv_reg;
        low_dyn_next   = low_dyn_reg;
        nonper_iv_next = nonper_iv_reg;
        sent_cnt_next  = sent_cnt_reg;
        send           = 1'b0;
        low_fc         = 1'b0;

        // Redraw the non-periodic interval on every tick in exponential mode while congestion control is disabled.
        if (!dcc_en_reg && expo_mode) begin
            nonper_iv_next = {1'b0, min_iv_reg} + {1'b0, tick_reg.random_extra_ms};
        end

        if (due) begin
            priority if (fixed_mode || expo_mode) begin
                send = 1'b1;
            end else if (hdg_changed || pos_changed || spd_changed) begin
                send          = 1'b1;
                adapt_iv_next = (elapsed < {16'd0, max_iv_reg}) ? elapsed[15:0] : max_iv_reg;
                low_dyn_next  = 2'd0;
            end else if (elapsed >= {16'd0, adapt_iv_reg}) begin
                send         = 1'b1;
                low_dyn_next = low_dyn_inc;
                if (low_dyn_inc >= LOW_DYNAMICS_LIMIT) begin
                    adapt_iv_next = max_iv_reg;
                end
            end
        end

        if (send) begin
            last_x_next    = tick_reg.pos_x_cm;
            last_y_next    = tick_reg.pos_y_cm;
            last_spd_next  = tick_reg.speed_now;
            last_hdg_next  = tick_reg.heading_now;
            last_send_next = tick_reg.now_ms;
            if (first_low_reg || ((tick_reg.now_ms - last_low_reg) >= LOW_FREQ_INTERVAL_MS)) begin
                low_fc         = 1'b1;
                last_low_next  = tick_reg.now_ms;
                first_low_next = 1'b0;
            end
            sent_cnt_next = sent_cnt_reg + 16'd1;
        end

        res_next.send               = send;
        res_next.low_freq_container = low_fc;
        res_next.message_count      = sent_cnt_reg;
    end

    // Commit state only when the held tick moves into the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_send_reg <= 32'd0;
            last_low_reg  <= 32'd0;
            first_low_reg <= 1'b1;
            last_hdg_reg  <= 12'd0;
            last_x_reg    <= 32'd0;
            last_y_reg    <= 32'd0;
            last_spd_reg  <= 16'd0;
            adapt_iv_reg  <= RST_MAX_INTERVAL;
            low_dyn_reg   <= 2'd0;
            nonper_iv_reg <= {1'b0, RST_MIN_INTERVAL};
            sent_cnt_reg  <= 16'd0;
        end else if (tick_valid_reg && advance) begin
            last_send_reg <= last_send_next;
            last_low_reg  <= last_low_next;
            first_low_reg <= first_low_next;
            last_hdg_reg  <= last_hdg_next;
            last_x_reg    <= last_x_next;
            last_y_reg    <= last_y_next;
            last_spd_reg  <= last_spd_next;
            adapt_iv_reg  <= adapt_iv_next;
            low_dyn_reg   <= low_dyn_next;
            nonper_iv_reg <= nonper_iv_next;
            sent_cnt_reg  <= sent_cnt_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (advance) begin
            res_valid_reg <= tick_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (tick_valid_reg && advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {(M_TDATA_W - $bits(result_t))'(0), res_reg};

endmodule

`default_nettype wire

// ===== tb/sv/cgt_decision_checker.sv =====
// Decision checker for the CAM generation trigger: watches tick, result and register channels.
// Predicts each send decision from its own copy of the registers and history, then compares.
// Depends on cgt_pkg for register indexes, reset values and item layouts.

module cgt_decision_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [cgt_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [cgt_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [cgt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cgt_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              mismatch_count,
    output int                              decisions_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import cgt_pkg::*;

    // Register copy
    logic [15:0] min_iv, max_iv, spd_thr;
    logic [10:0] hdg_thr;
    logic [19:0] pos_thr;
    logic        dcc_en;
    logic [1:0]  mode;
    logic [31:0] startup;

    // History copy
    logic [31:0]        last_send, last_low, adaptive;
    logic               first_low;
    logic [11:0]        last_hdg;
    logic signed [31:0] last_x, last_y;
    logic signed [15:0] last_spd;
    logic [1:0]         low_dyn;
    logic [16:0]        np_iv;
    logic [15:0]        sent;

    result_t expected_decisions[$];
    int      fails = 0;

    function automatic result_t decide_tick(input tick_t t);
        logic [31:0]    elapsed, final_iv, low_age;
        logic [15:0]    floor_iv;
        int             hd, th, sd;
        longint         dx, dy, pthr;
        logic           hdg_moved, pos_moved, spd_moved, fire;
        result_t        r;
        elapsed  = t.now_ms - last_send;
        final_iv = 32'(min_iv);
        if (dcc_en) begin
            floor_iv = (t.dcc_interval_ms > min_iv) ? t.dcc_interval_ms : min_iv;
            final_iv = 32'((floor_iv < max_iv) ? floor_iv : max_iv);
        end else if (mode[RATE_EXPO_BIT]) begin
            // use the stored draw, then redraw for the next tick
            final_iv = 32'(np_iv);
            np_iv    = min_iv + t.random_extra_ms;
        end

        // heading distance folded onto the circle
        hd = int'(t.heading_now) - int'(last_hdg);
        if (hd < 0) hd = -hd;
        hd = hd % int'(FULL_CIRCLE_DD);
        th = int'(hdg_thr);
        hdg_moved = !(hd <= th || hd >= int'(FULL_CIRCLE_DD) - th);

        dx = longint'($signed(t.pos_x_cm)) - longint'(last_x);
        dy = longint'($signed(t.pos_y_cm)) - longint'(last_y);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        pthr = longint'(pos_thr);
        pos_moved = dx > pthr || dy > pthr || dx * dx + dy * dy > pthr * pthr;

        sd = int'($signed(t.speed_now)) - int'(last_spd);
        if (sd < 0) sd = -sd;
        spd_moved = sd > int'(spd_thr);

        fire = 1'b0;
        if (elapsed >= final_iv && t.now_ms > startup) begin
            if (mode[RATE_FIXED_BIT] || mode[RATE_EXPO_BIT]) begin
                fire = 1'b1;
            end else if (hdg_moved || pos_moved || spd_moved) begin
                fire     = 1'b1;
                adaptive = (elapsed < 32'(max_iv)) ? elapsed : 32'(max_iv);
                low_dyn  = '0;
            end else if (elapsed >= adaptive) begin
                fire = 1'b1;
                if (low_dyn != LOW_DYNAMICS_SAT) low_dyn++;
                if (low_dyn >= LOW_DYNAMICS_LIMIT) adaptive = 32'(max_iv);
            end
        end

        r.send               = fire;
        r.low_freq_container = 1'b0;
        r.message_count      = sent;
        if (fire) begin
            last_x    = t.pos_x_cm;
            last_y    = t.pos_y_cm;
            last_spd  = t.speed_now;
            last_hdg  = t.heading_now;
            last_send = t.now_ms;
            low_age   = t.now_ms - last_low;
            if (first_low || low_age >= LOW_FREQ_INTERVAL_MS) begin
                r.low_freq_container = 1'b1;
                last_low  = t.now_ms;
                first_low = 1'b0;
            end
            sent++;
        end
        return r;
    endfunction

    task automatic report_field(input string field, input logic [15:0] want,
                                input logic [15:0] got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        fails++;
    endtask

    always @(posedge aclk) begin
        result_t got, want;
        if (!aresetn) begin
            min_iv     = RST_MIN_INTERVAL;
            max_iv     = RST_MAX_INTERVAL;
            hdg_thr    = RST_HEADING_THR;
            pos_thr    = RST_POSITION_THR;
            spd_thr    = RST_SPEED_THR;
            dcc_en     = 1'b0;
            mode       = '0;
            startup    = '0;
            last_send  = '0;
            last_low   = '0;
            first_low  = 1'b1;
            last_hdg   = '0;
            last_x     = '0;
            last_y     = '0;
            last_spd   = '0;
            adaptive   = 32'(RST_MAX_INTERVAL);
            low_dyn    = '0;
            np_iv      = 17'(RST_MIN_INTERVAL);
            sent       = '0;
            expected_decisions.delete();
        end else begin
            // retire before predicting; a tick never yields its result in the same cycle
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(result_t)-1:0];
                if (expected_decisions.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual send=%0b low=%0b count=%0d",
                             $time, got.send, got.low_freq_container, got.message_count);
                    fails++;
                end else begin
                    want = expected_decisions.pop_front();
                    if (got.send !== want.send)
                        report_field("send", 16'(want.send), 16'(got.send));
                    if (got.low_freq_container !== want.low_freq_container)
                        report_field("low_freq_container", 16'(want.low_freq_container),
                                     16'(got.low_freq_container));
                    if (got.message_count !== want.message_count)
                        report_field("message_count", want.message_count, got.message_count);
                end
            end
            if (s_tvalid && s_tready)
                expected_decisions.push_back(decide_tick(s_tdata[$bits(tick_t)-1:0]));
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MIN_INTERVAL: min_iv  = cfg_data[15:0];
                    REG_MAX_INTERVAL: max_iv  = cfg_data[15:0];
                    REG_HEADING_THR:  hdg_thr = cfg_data[10:0];
                    REG_POSITION_THR: pos_thr = cfg_data[19:0];
                    REG_SPEED_THR:    spd_thr = cfg_data[15:0];
                    REG_DCC_ENABLE:   dcc_en  = cfg_data[0];
                    REG_RATE_MODE:    mode    = cfg_data[1:0];
                    REG_STARTUP_TIME: startup = cfg_data;
                    default: ;
                endcase
            end
        end
        mismatch_count    <= fails;
        decisions_pending <= expected_decisions.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the CAM generation trigger bench: clock, reset, tick and register stimulus, verdict.
// Instantiates cam_generation_trigger beside cgt_decision_checker, which does all checking.
// Depends on cgt_pkg for register indexes, widths and the tick layout.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import cgt_pkg::*;

    // Rate mode codes as written to the rate mode register
    localparam logic [1:0] MODE_DYNAMICS = 2'd0;
    localparam logic [1:0] MODE_FIXED    = 2'd1;
    localparam logic [1:0] MODE_EXPO     = 2'd2;
    localparam logic [1:0] MODE_BOTH     = 2'd3;

    localparam int PHASES          = 12;
    localparam int TICKS_PER_PHASE = 100;

    // One full register setting, written field by field between phases
    typedef struct packed {
        logic [15:0] min_iv;
        logic [15:0] max_iv;
        logic [10:0] hdg_thr;
        logic [19:0] pos_thr;
        logic [15:0] spd_thr;
        logic        dcc_en;
        logic [1:0]  mode;
        logic [31:0] startup;
    } reg_plan_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    // now_ms, heading_now, pos_x_cm, pos_y_cm, speed_now, dcc_interval_ms,
    // random_extra_ms from the lowest bit up, zero pad
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    // send, low_freq_container, message_count from the lowest bit up, zero pad
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    int                     mismatch_count;
    int                     decisions_pending;

    // Vehicle trajectory that the well-formed ticks follow
    logic [31:0] now_cur;
    int          hdg_cur;
    logic [31:0] x_cur, y_cur;
    logic [15:0] spd_cur;

    // Receiver stall pattern state
    int ready_style = 0;
    int style_left  = 0;
    int stall_left  = 0;

    cam_generation_trigger i_dut (.*);

    cgt_decision_checker i_checker (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: switch between always ready, coin flips, sparse ready and long stalls
    always @(posedge aclk) begin
        if (style_left == 0) begin
            ready_style = $urandom_range(0, 3);
            style_left  = $urandom_range(20, 200);
        end else begin
            style_left--;
        end
        case (ready_style)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 0);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: begin
                if (stall_left != 0) begin
                    stall_left--;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(4, 12);
                end
            end
        endcase
    end

    // Hard stop well past the slowest legal run
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic tick_t make_tick(input logic [31:0] now, input logic [11:0] hdg,
                                        input logic [31:0] x, input logic [31:0] y,
                                        input logic [15:0] spd, input logic [15:0] dcc,
                                        input logic [15:0] rnd);
        tick_t t;
        t.now_ms          = now;
        t.heading_now     = hdg;
        t.pos_x_cm        = x;
        t.pos_y_cm        = y;
        t.speed_now       = spd;
        t.dcc_interval_ms = dcc;
        t.random_extra_ms = rnd;
        return t;
    endfunction

    // Present one tick request and hold it until taken; leave tvalid high for a follow-on
    task automatic send_tick(input tick_t t);
        s_tdata  <= {{(S_TDATA_W - $bits(tick_t)){1'b0}}, t};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (s_tready !== 1'b1);
    endtask

    // Present one register write; the caller drops cfg_valid after the last one
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
    endtask

    // Hold until every predicted result has been taken, then let the pipeline settle
    task automatic wait_all_decided;
        do @(posedge aclk); while (decisions_pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        int        phase, k, b, burst, gap, kind;
        logic      gappy;
        reg_plan_t plan;
        tick_t     tick;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed ticks under reset settings: startup edge, heading wrap and
        // out-of-range heading, diagonal position step, speed and position extremes,
        // extreme congestion and random samples, time wrap
        send_tick(make_tick(32'd0,    12'd0,    32'd0, 32'd0, 16'd0, 16'd0, 16'd0));
        send_tick(make_tick(32'd99,   12'd0,    32'd0, 32'd0, 16'd0, 16'hFFFF, 16'hFFFF));
        send_tick(make_tick(32'd100,  12'd0,    32'd0, 32'd0, 16'd0, 16'd0, 16'd0));
        send_tick(make_tick(32'd150,  12'd41,   32'd0, 32'd0, 16'd0, 16'd0, 16'd0));
        send_tick(make_tick(32'd200,  12'd41,   32'd0, 32'd0, 16'd0, 16'd0, 16'd0));
        send_tick(make_tick(32'd300,  12'd10,   32'd0, 32'd0, 16'd0, 16'd0, 16'd0));
        send_tick(make_tick(32'd450,  12'd3590, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0));
        send_tick(make_tick(32'd600,  12'd3590, 32'd300, 32'd300, 16'd0, 16'd0, 16'd0));
        send_tick(make_tick(32'd750,  12'd3590, 32'd300, 32'd300, 16'd51, 16'd0, 16'd0));
        send_tick(make_tick(32'd900,  12'd3590, 32'd300, 32'd300, 16'h8000, 16'd0, 16'd0));
        send_tick(make_tick(32'd1050, 12'd3590, 32'd300, 32'd300, 16'h7FFF, 16'd0, 16'd0));
        send_tick(make_tick(32'd1200, 12'hFFF,  32'd300, 32'd300, 16'h7FFF, 16'd0, 16'd0));
        send_tick(make_tick(32'd1350, 12'hFFF,  32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF,
                            16'd0, 16'd0));
        send_tick(make_tick(32'd1500, 12'hFFF,  32'h7FFF_FFFF, 32'h8000_0000, 16'h8000,
                            16'd0, 16'd0));
        send_tick(make_tick(32'd1600, 12'd0,    32'h7FFF_FFFF, 32'h8000_0000, 16'h8000,
                            16'd0, 16'd0));
        send_tick(make_tick(32'hFFFF_FF00, 12'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                            16'hFFFF, 16'hFFFF));
        send_tick(make_tick(32'hFFFF_FFFF, 12'd1800, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                            16'd0, 16'd0));
        send_tick(make_tick(32'd20,   12'd1800, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0));
        send_tick(make_tick(32'd130,  12'd2048, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0));
        send_tick(make_tick(32'd131,  12'd2048, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0));
        s_tvalid <= 1'b0;
        wait_all_decided();

        now_cur = 32'd200;
        hdg_cur = 0;
        x_cur   = '0;
        y_cur   = '0;
        spd_cur = '0;

        for (phase = 0; phase < PHASES; phase++) begin
            // Pick the setting: fixed corners first, then random draws
            case (phase)
                0: plan = '{16'd100, 16'd1000, 11'd40, 20'd400, 16'd50, 1'b0, MODE_DYNAMICS,
                            now_cur + 32'd300};
                1: plan = '{16'd0, 16'd0, 11'd0, 20'd0, 16'd0, 1'b0, MODE_DYNAMICS, 32'd0};
                2: plan = '{16'hFFFF, 16'hFFFF, 11'h7FF, 20'hFFFFF, 16'hFFFF, 1'b0, MODE_FIXED,
                            32'd0};
                3: plan = '{16'd50, 16'd300, 11'd20, 20'd200, 16'd30, 1'b1, MODE_DYNAMICS, 32'd0};
                4: plan = '{16'd400, 16'd100, 11'd40, 20'd400, 16'd50, 1'b1, MODE_FIXED, 32'd0};
                5: plan = '{16'd30, 16'd1000, 11'd40, 20'd400, 16'd50, 1'b0, MODE_EXPO, 32'd0};
                6: plan = '{16'd20, 16'd500, 11'd40, 20'd400, 16'd50, 1'b0, MODE_BOTH, 32'd0};
                7: plan = '{16'd60, 16'd700, 11'd40, 20'd400, 16'd50, 1'b1, MODE_EXPO, 32'd0};
                8: plan = '{16'd0, 16'hFFFF, 11'd1800, 20'd1000000, 16'hFFFF, 1'b0,
                            MODE_DYNAMICS, 32'hFFFF_FFFF};
                default: plan = '{16'($urandom_range(0, 300)), 16'($urandom_range(0, 2000)),
                                  11'($urandom_range(0, 200)), 20'($urandom_range(0, 1500)),
                                  16'($urandom_range(0, 150)), 1'($urandom_range(0, 1)),
                                  2'($urandom_range(0, 3)),
                                  ($urandom_range(0, 3) == 0) ?
                                      now_cur + $urandom_range(0, 500) : 32'd0};
            endcase

            // The block is idle here: every register gets the new setting
            write_reg(REG_MIN_INTERVAL, 32'(plan.min_iv));
            write_reg(REG_MAX_INTERVAL, 32'(plan.max_iv));
            write_reg(REG_HEADING_THR,  32'(plan.hdg_thr));
            write_reg(REG_POSITION_THR, 32'(plan.pos_thr));
            write_reg(REG_SPEED_THR,    32'(plan.spd_thr));
            write_reg(REG_DCC_ENABLE,   32'(plan.dcc_en));
            write_reg(REG_RATE_MODE,    32'(plan.mode));
            write_reg(REG_STARTUP_TIME, plan.startup);
            cfg_valid <= 1'b0;

            // Every third phase streams without sender gaps
            gappy = (phase % 3 != 2);
            k = 0;
            while (k < TICKS_PER_PHASE) begin
                burst = $urandom_range(1, 24);
                for (b = 0; b < burst && k < TICKS_PER_PHASE; b++) begin
                    kind = $urandom_range(0, 19);
                    if (kind == 0) begin
                        // noise: a tick off the trajectory
                        tick = make_tick($urandom, 12'($urandom), $urandom, $urandom,
                                         16'($urandom), 16'($urandom), 16'($urandom));
                    end else begin
                        // advance the vehicle; now and then jump far in time
                        if (kind == 1) now_cur = now_cur + $urandom;
                        else now_cur = now_cur + $urandom_range(0, 40);
                        hdg_cur = (hdg_cur + int'($urandom_range(0, 120)) - 60 + 3600) % 3600;
                        x_cur   = x_cur + $urandom_range(0, 800) - 32'd400;
                        y_cur   = y_cur + $urandom_range(0, 800) - 32'd400;
                        spd_cur = spd_cur + $urandom_range(0, 120) - 60;
                        tick = make_tick(now_cur, 12'(hdg_cur), x_cur, y_cur, spd_cur,
                                         ($urandom_range(0, 7) == 0) ?
                                             16'($urandom) : 16'($urandom_range(0, 1200)),
                                         ($urandom_range(0, 7) == 0) ?
                                             16'($urandom) : 16'($urandom_range(0, 400)));
                    end
                    send_tick(tick);
                    k++;
                end
                if (gappy) begin
                    gap = $urandom_range(0, 7);
                    if (gap != 0) begin
                        s_tvalid <= 1'b0;
                        repeat (gap) @(posedge aclk);
                    end
                end
                // now and then hold off until the result side has caught up completely
                if ($urandom_range(0, 24) == 0) begin
                    s_tvalid <= 1'b0;
                    wait_all_decided();
                end
            end
            s_tvalid <= 1'b0;
            wait_all_decided();
        end

        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && decisions_pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
